FILE: design/mlh_pkg.sv
// Shared types and constants for the multi-player link handshake tracker.
// No dependencies; imported by every module of the block.
package mlh_pkg;

  localparam logic [15:0] SEND_IDLE   = 16'hD951;
  localparam logic [15:0] SEND_READY  = 16'h26AE;
  localparam logic [15:0] SEND_ABORT  = 16'hE4E4;
  localparam logic [15:0] PEER_ABSENT = 16'hFFFF;

  localparam int unsigned SEQ_W = 13;
  localparam logic [SEQ_W-1:0] SEQ_FLOOR       = 13'h0100;
  localparam logic [SEQ_W-1:0] SEQ_FLOOR_LIMIT = 13'h00FF;

  localparam logic [4:0]  STABLE_MAX      = 5'd30;
  localparam logic [4:0]  STABLE_SAT_FROM = 5'd29;
  localparam logic [15:0] GOOD_TAG_CHECK  = 16'd3;
  localparam logic [15:0] GOOD_IDLE_EST   = 16'd19;
  localparam logic [15:0] GOOD_READY      = 16'd30;

  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // Register index, taken from paddr[2]
  localparam logic REG_LINK_MODE = 1'b0;
  localparam logic REG_LOCAL_TAG = 1'b1;

  localparam logic [1:0] MODE_STABLE     = 2'd0;
  localparam logic [1:0] MODE_STABLE_ALT = 2'd2;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_PEER        = 2'd1,
    STAT_ESTABLISHED = 2'd2,
    STAT_ABORTED     = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0] link_mode;
    logic [2:0] local_tag;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  link_id;
    logic        error_bit;
    logic        si_level;
    logic [15:0] rx_word0;
    logic [15:0] rx_word1;
    logic [15:0] rx_word2;
    logic [15:0] rx_word3;
  } item_t;

  typedef struct packed {
    logic        send_valid;
    logic [15:0] send_word;
    logic [1:0]  link_status;
    logic [2:0]  player_count;
    logic        tag_mismatch;
    logic        error_flag;
    logic [1:0]  unit_id;
    logic [4:0]  stable_count;
    logic [3:0]  absent_mask;
    logic [7:0]  event_count;
  } result_t;

endpackage

FILE: design/mlh_cfg.sv
// APB register file: link mode and local tag.
// Depends on mlh_pkg.
module mlh_cfg import mlh_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (paddr[2])
        REG_LINK_MODE: cfg_q.link_mode <= pwdata[1:0];
        REG_LOCAL_TAG: cfg_q.local_tag <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LINK_MODE: prdata = {{(APB_DATA_W-2){1'b0}}, cfg_q.link_mode};
      REG_LOCAL_TAG: prdata = {{(APB_DATA_W-3){1'b0}}, cfg_q.local_tag};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/mlh_core.sv
// Link state registers and the single-pass update logic for one transfer.
// Depends on mlh_pkg.
module mlh_core import mlh_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  logic [7:0]  event_q,  event_d;
  logic [1:0]  unit_d;
  logic        error_d;
  logic        mism_q,   mism_d;
  status_e     status_q, status_d;
  logic [2:0]  players_q, players_d;
  logic [15:0] seqw_q,   seqw_d;
  logic [15:0] good_q,   good_d;
  logic [3:0]  absent_q, absent_d;
  logic [15:0] prev_q [3];
  logic [15:0] prev_d [3];
  logic [4:0]  stable_q, stable_d;

  always_comb begin
    logic [15:0]      w [4];
    logic             sent;
    logic [15:0]      word;
    logic             stab_clr;
    logic [4:0]       stab_base;
    logic [SEQ_W-1:0] seq;
    logic             contig;

    w[0] = item_i.rx_word0;
    w[1] = item_i.rx_word1;
    w[2] = item_i.rx_word2;
    w[3] = item_i.rx_word3;

    event_d   = 8'(event_q + 8'd1);
    unit_d    = item_i.link_id;
    error_d   = item_i.error_bit;
    mism_d    = mism_q;
    status_d  = status_q;
    players_d = players_q;
    seqw_d    = seqw_q;
    good_d    = good_q;
    absent_d  = absent_q;
    stable_d  = stable_q;
    for (int i = 0; i < 3; i++) prev_d[i] = prev_q[i];
    sent      = 1'b0;
    word      = '0;
    stab_clr  = 1'b0;
    stab_base = '0;
    seq       = '0;
    contig    = 1'b1;

    if (cfg_i.link_mode == MODE_STABLE || cfg_i.link_mode == MODE_STABLE_ALT) begin
      sent = item_i.si_level;
      word = SEND_IDLE;
      stab_clr = (w[1] == PEER_ABSENT);
      for (int i = 0; i < 3; i++) begin
        if (w[i+1] != prev_q[i]) stab_clr = 1'b1;
        prev_d[i] = w[i+1];
      end
      stab_base = stab_clr ? 5'd0 : stable_q;
      stable_d  = (stab_base >= STABLE_SAT_FROM) ? STABLE_MAX : 5'(stab_base + 5'd1);
    end else if (w[0] == SEND_ABORT) begin
      sent     = 1'b1;
      word     = SEND_ABORT;
      status_d = STAT_ABORTED;
    end else begin
      if (!item_i.si_level) begin
        if (good_q > GOOD_IDLE_EST) status_d = STAT_ESTABLISHED;
      end else begin
        seq = SEQ_W'(seqw_q[SEQ_W-1:0] + 1'b1);
        if (seq <= SEQ_FLOOR_LIMIT) seq = SEQ_FLOOR;
        if (seq == w[0][SEQ_W-1:0]) begin
          if (good_q > GOOD_TAG_CHECK) begin
            if (w[0][15:SEQ_W] == cfg_i.local_tag) begin
              mism_d = 1'b0;
              good_d = 16'(good_q + 16'd1);
            end else if (w[0][15:SEQ_W] != 3'd0) begin
              mism_d = 1'b1;
              good_d = '0;
            end
          end else begin
            good_d = 16'(good_q + 16'd1);
          end
        end else begin
          good_d = '0;
        end
        seqw_d = w[0];
        sent   = 1'b1;
        if (good_d > GOOD_READY) begin
          status_d = STAT_ESTABLISHED;
          word     = SEND_READY;
        end else begin
          status_d = STAT_OK;
          word     = SEND_IDLE;
        end
      end

      // Player chain: peers must answer in order, a gap breaks the count
      players_d = 3'd1;
      absent_d  = '0;
      for (int i = 1; i <= 3; i++) begin
        if (w[i] == PEER_ABSENT) absent_d[i] = 1'b1;
        if (!absent_q[i]) begin
          if (w[i] == SEND_READY) begin
            if (w[i-1] == PEER_ABSENT) begin
              contig   = 1'b0;
              status_d = STAT_PEER;
            end
            players_d = contig ? 3'(players_d + 3'd1) : 3'd1;
          end else if (w[i] == SEND_IDLE) begin
            status_d = STAT_PEER;
            if (w[i-1] == PEER_ABSENT) begin
              contig = 1'b0;
              good_d = '0;
            end
          end else begin
            contig = 1'b0;
          end
        end else begin
          contig = 1'b0;
        end
      end
    end

    result_o.send_valid   = sent;
    result_o.send_word    = sent ? word : 16'd0;
    result_o.link_status  = status_d;
    result_o.player_count = players_d;
    result_o.tag_mismatch = mism_d;
    result_o.error_flag   = error_d;
    result_o.unit_id      = unit_d;
    result_o.stable_count = stable_d;
    result_o.absent_mask  = absent_d;
    result_o.event_count  = event_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      event_q   <= '0;
      mism_q    <= 1'b0;
      status_q  <= STAT_OK;
      players_q <= '0;
      seqw_q    <= '0;
      good_q    <= '0;
      absent_q  <= '0;
      stable_q  <= '0;
      for (int i = 0; i < 3; i++) prev_q[i] <= '0;
    end else if (step_i) begin
      event_q   <= event_d;
      mism_q    <= mism_d;
      status_q  <= status_d;
      players_q <= players_d;
      seqw_q    <= seqw_d;
      good_q    <= good_d;
      absent_q  <= absent_d;
      stable_q  <= stable_d;
      for (int i = 0; i < 3; i++) prev_q[i] <= prev_d[i];
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |=> event_q == 8'($past(event_q) + 8'd1))
    else $error("event counter did not advance by one per transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(good_q) && $stable(stable_q) && $stable(status_q))
    else $error("link state changed without a transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stable_q <= STABLE_MAX && !absent_q[0])
    else $error("stable count or absent mask out of range");

endmodule

FILE: design/multiplay_link_handshake.sv
// Multi-player link handshake tracker: top level with input and result registers.
// Depends on mlh_pkg, mlh_cfg and mlh_core.
//
// Usage:
//   s_axis carries one request per completed multi-player transfer: the control
//   bits and the four received words. m_axis returns exactly one result per
//   request: the send word (if any), link status, player count, flags and
//   counters as they stand after that transfer. The APB port sets link_mode
//   (0x0) and local_tag (0x4); write them only while no request is in flight.
//   A request accepted into the input register is evaluated from it, and its
//   result is captured in the result register once that register is free.
//   Throughput is one request per cycle while m_axis_tready stays high; the
//   per-request update is a single pass of compare logic against the link state
//   registers. When m_axis_tready is low the result register holds; the input
//   register still takes one more request, after which s_axis_tready drops until
//   the result is taken. Reset clears all link state, counters and valid flags.
module multiplay_link_handshake import mlh_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [1:0] link_id, [2] error_bit, [3] si_level, [19:4] rx_word0,
  // [35:20] rx_word1, [51:36] rx_word2, [67:52] rx_word3, [71:68] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] send_valid, [16:1] send_word, [18:17] link_status, [21:19] player_count,
  // [22] tag_mismatch, [23] error_flag, [25:24] unit_id, [30:26] stable_count,
  // [34:31] absent_mask, [42:35] event_count, [47:43] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t    cfg;
  item_t   in_q;
  logic    in_valid_q;
  result_t res;
  result_t out_q;
  logic    out_valid_q;
  logic    fire;

  mlh_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.link_id   <= s_axis_tdata[1:0];
      in_q.error_bit <= s_axis_tdata[2];
      in_q.si_level  <= s_axis_tdata[3];
      in_q.rx_word0  <= s_axis_tdata[19:4];
      in_q.rx_word1  <= s_axis_tdata[35:20];
      in_q.rx_word2  <= s_axis_tdata[51:36];
      in_q.rx_word3  <= s_axis_tdata[67:52];
    end
  end

  mlh_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (fire),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q.event_count, out_q.absent_mask, out_q.stable_count,
                          out_q.unit_id, out_q.error_flag, out_q.tag_mismatch,
                          out_q.player_count, out_q.link_status, out_q.send_word,
                          out_q.send_valid};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> m_axis_tvalid)
    else $error("evaluated request produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !fire |=> in_valid_q && $stable(in_q))
    else $error("pending request dropped or changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.send_valid || out_q.send_word == 16'd0))
    else $error("send word present without send_valid");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready && in_valid_q |-> !s_axis_tready)
    else $error("input accepted with both stages full");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for multiplay_link_handshake: directed transfers, then random phases.
// Depends on mlh_pkg; predicts each result in-bench and compares it on the m_axis side.
module testbench;
  import mlh_pkg::*;

  localparam logic [1:0] MODE_HANDSHAKE     = 2'd1;
  localparam logic [1:0] MODE_HANDSHAKE_ALT = 2'd3;
  localparam int N_DIRECTED      = 20;
  localparam int N_PHASES        = 12;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int TAIL_CYCLES     = 10;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  tag;
    logic [1:0]  id;
    logic        err;
    logic        si;
    logic [15:0] w0;
    logic [15:0] w1;
    logic [15:0] w2;
    logic [15:0] w3;
    logic        typed;
    result_t     want;
  } directed_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  multiplay_link_handshake dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // Predicted link state
  logic [1:0]  link_mode_q;
  logic [2:0]  local_tag_q;
  logic [7:0]  event_q;
  logic [1:0]  unit_q;
  logic        error_q;
  logic        mismatch_q;
  status_e     status_q;
  logic [2:0]  players_q;
  logic [15:0] seq_q;
  logic [15:0] good_q;
  logic [3:0]  absent_q;
  logic [15:0] peer_hist [3];
  logic [4:0]  stable_q;

  result_t pending_results [$];
  int      mismatch_count = 0;
  int      idle_cycles = 0;
  int      burst_left = 0;
  int      clean_left = 0;
  bit      steady_sender = 1'b0;
  bit      hold_req = 1'b0;

  string field_names [10] = '{"send_valid", "send_word", "link_status", "player_count",
                              "tag_mismatch", "error_flag", "unit_id", "stable_count",
                              "absent_mask", "event_count"};

  logic [1:0] phase_modes [N_PHASES] = '{MODE_STABLE, MODE_HANDSHAKE, MODE_HANDSHAKE,
                                         MODE_STABLE_ALT, MODE_HANDSHAKE, MODE_HANDSHAKE_ALT,
                                         MODE_HANDSHAKE, MODE_STABLE, MODE_HANDSHAKE,
                                         MODE_STABLE_ALT, MODE_HANDSHAKE, MODE_HANDSHAKE};

  directed_row_t directed_rows [N_DIRECTED] = '{
    // stability mode, counter start and all-ones extremes
    '{MODE_STABLE, 3'd0, 2'd3, 1'b1, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
      {1'b1, SEND_IDLE, STAT_OK, 3'd0, 1'b0, 1'b1, 2'd3, 5'd1, 4'd0, 8'd1}},
    '{MODE_STABLE, 3'd0, 2'd0, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
      {1'b0, 16'h0000, STAT_OK, 3'd0, 1'b0, 1'b0, 2'd0, 5'd1, 4'd0, 8'd2}},
    '{MODE_STABLE, 3'd0, 2'd1, 1'b0, 1'b1, 16'h1234, 16'h1111, 16'h2222, 16'h3333, 1'b0, '0},
    '{MODE_STABLE, 3'd0, 2'd2, 1'b1, 1'b1, 16'h1234, 16'h1111, 16'h2222, 16'h3333, 1'b0, '0},
    '{MODE_STABLE, 3'd0, 2'd3, 1'b0, 1'b0, 16'h5678, 16'h1111, 16'h2222, 16'h3333, 1'b0, '0},
    // abort word leaves players, mask and stability count alone
    '{MODE_HANDSHAKE, 3'd0, 2'd2, 1'b0, 1'b1, SEND_ABORT, 16'h0000, 16'h0000, 16'h0000, 1'b1,
      {1'b1, SEND_ABORT, STAT_ABORTED, 3'd0, 1'b0, 1'b0, 2'd2, 5'd3, 4'd0, 8'd6}},
    // in-order sequence from the floor value, still evaluated after abort
    '{MODE_HANDSHAKE, 3'd0, 2'd0, 1'b0, 1'b1, 16'h0100, SEND_READY, SEND_IDLE, PEER_ABSENT,
      1'b0, '0},
    '{MODE_HANDSHAKE, 3'd0, 2'd1, 1'b0, 1'b1, 16'h0101, SEND_READY, SEND_READY, SEND_READY,
      1'b0, '0},
    '{MODE_HANDSHAKE, 3'd0, 2'd1, 1'b0, 1'b1, 16'h0102, SEND_READY, SEND_READY, SEND_READY,
      1'b0, '0},
    '{MODE_HANDSHAKE, 3'd0, 2'd0, 1'b1, 1'b1, 16'h0103, SEND_IDLE, SEND_IDLE, SEND_IDLE,
      1'b0, '0},
    '{MODE_HANDSHAKE, 3'd0, 2'd0, 1'b0, 1'b1, 16'h0104, 16'h1234, SEND_READY, PEER_ABSENT,
      1'b0, '0},
    // foreign tag once the tag check is armed
    '{MODE_HANDSHAKE, 3'd0, 2'd0, 1'b0, 1'b1, 16'hE105, 16'h0000, 16'h0000, 16'h0000,
      1'b0, '0},
    // SI low: no send, players still counted
    '{MODE_HANDSHAKE, 3'd0, 2'd0, 1'b0, 1'b0, 16'h0000, PEER_ABSENT, SEND_READY, SEND_IDLE,
      1'b0, '0},
    // sequence wrap back to the floor
    '{MODE_HANDSHAKE, 3'd7, 2'd0, 1'b0, 1'b1, 16'h1FFF, 16'h0000, 16'h0000, 16'h0000,
      1'b0, '0},
    '{MODE_HANDSHAKE, 3'd7, 2'd0, 1'b0, 1'b1, 16'hE100, SEND_READY, SEND_READY, 16'h0000,
      1'b0, '0},
    // idle word right after an absent word 0
    '{MODE_HANDSHAKE, 3'd7, 2'd3, 1'b1, 1'b1, 16'hFFFF, SEND_IDLE, 16'h0000, 16'h0000,
      1'b0, '0},
    '{MODE_HANDSHAKE_ALT, 3'd7, 2'd0, 1'b0, 1'b1, 16'h0100, SEND_READY, SEND_READY, SEND_READY,
      1'b0, '0},
    '{MODE_STABLE_ALT, 3'd5, 2'd1, 1'b1, 1'b1, 16'hABCD, 16'h4444, 16'h5555, 16'h6666,
      1'b0, '0},
    '{MODE_STABLE_ALT, 3'd5, 2'd1, 1'b1, 1'b0, 16'hABCD, 16'h4444, 16'h5555, 16'h6666,
      1'b0, '0},
    '{MODE_STABLE_ALT, 3'd5, 2'd2, 1'b0, 1'b1, 16'h0000, 16'h4444, 16'h5555, PEER_ABSENT,
      1'b0, '0}
  };

  function automatic logic [IN_DATA_W-1:0] pack_transfer(item_t it);
    return {{(IN_DATA_W-68){1'b0}}, it.rx_word3, it.rx_word2, it.rx_word1, it.rx_word0,
            it.si_level, it.error_bit, it.link_id};
  endfunction

  function automatic result_t unpack_result(logic [OUT_DATA_W-1:0] d);
    result_t r;
    r.send_valid   = d[0];
    r.send_word    = d[16:1];
    r.link_status  = d[18:17];
    r.player_count = d[21:19];
    r.tag_mismatch = d[22];
    r.error_flag   = d[23];
    r.unit_id      = d[25:24];
    r.stable_count = d[30:26];
    r.absent_mask  = d[34:31];
    r.event_count  = d[42:35];
    return r;
  endfunction

  function automatic logic [15:0] result_field(result_t r, int k);
    case (k)
      0: return 16'(r.send_valid);
      1: return r.send_word;
      2: return 16'(r.link_status);
      3: return 16'(r.player_count);
      4: return 16'(r.tag_mismatch);
      5: return 16'(r.error_flag);
      6: return 16'(r.unit_id);
      7: return 16'(r.stable_count);
      8: return 16'(r.absent_mask);
      default: return 16'(r.event_count);
    endcase
  endfunction

  // Sequence number that word 0 must carry to count as in order
  function automatic logic [12:0] expected_sequence();
    logic [12:0] s;
    s = seq_q[12:0] + 13'd1;
    if (s <= SEQ_FLOOR_LIMIT) s = SEQ_FLOOR;
    return s;
  endfunction

  task automatic predict_transfer(input item_t it, output result_t res);
    logic [15:0] w [4];
    logic        sent;
    logic [15:0] word;
    logic [3:0]  prev;
    logic        contig;
    w[0] = it.rx_word0;
    w[1] = it.rx_word1;
    w[2] = it.rx_word2;
    w[3] = it.rx_word3;
    sent = 1'b0;
    word = '0;
    contig = 1'b1;
    event_q = event_q + 8'd1;
    unit_q = it.link_id;
    error_q = it.error_bit;
    if (link_mode_q == MODE_STABLE || link_mode_q == MODE_STABLE_ALT) begin
      if (it.si_level) begin
        sent = 1'b1;
        word = SEND_IDLE;
      end
      if (w[1] == PEER_ABSENT) stable_q = '0;
      for (int i = 0; i < 3; i++) begin
        if (w[i+1] != peer_hist[i]) stable_q = '0;
        peer_hist[i] = w[i+1];
      end
      stable_q = (stable_q >= STABLE_SAT_FROM) ? STABLE_MAX : stable_q + 5'd1;
    end else if (w[0] == SEND_ABORT) begin
      sent = 1'b1;
      word = SEND_ABORT;
      status_q = STAT_ABORTED;
    end else begin
      if (!it.si_level) begin
        if (good_q > GOOD_IDLE_EST) status_q = STAT_ESTABLISHED;
      end else begin
        if (expected_sequence() == w[0][12:0]) begin
          if (good_q > GOOD_TAG_CHECK) begin
            if (w[0][15:13] == local_tag_q) begin
              mismatch_q = 1'b0;
              good_q = good_q + 16'd1;
            end else if (w[0][15:13] != 3'd0) begin
              mismatch_q = 1'b1;
              good_q = '0;
            end
          end else begin
            good_q = good_q + 16'd1;
          end
        end else begin
          good_q = '0;
        end
        seq_q = w[0];
        sent = 1'b1;
        if (good_q > GOOD_READY) begin
          status_q = STAT_ESTABLISHED;
          word = SEND_READY;
        end else begin
          status_q = STAT_OK;
          word = SEND_IDLE;
        end
      end
      // player count walks the peers until the first gap
      players_q = 3'd1;
      prev = absent_q;
      absent_q = '0;
      for (int i = 1; i <= 3; i++) begin
        if (w[i] == PEER_ABSENT) absent_q[i] = 1'b1;
        if (!prev[i]) begin
          if (w[i] == SEND_READY) begin
            if (w[i-1] == PEER_ABSENT) begin
              contig = 1'b0;
              status_q = STAT_PEER;
            end
            players_q = contig ? players_q + 3'd1 : 3'd1;
          end else if (w[i] == SEND_IDLE) begin
            status_q = STAT_PEER;
            if (w[i-1] == PEER_ABSENT) begin
              contig = 1'b0;
              good_q = '0;
            end
          end else begin
            contig = 1'b0;
          end
        end else begin
          contig = 1'b0;
        end
      end
    end
    res.send_valid   = sent;
    res.send_word    = sent ? word : 16'h0000;
    res.link_status  = status_q;
    res.player_count = players_q;
    res.tag_mismatch = mismatch_q;
    res.error_flag   = error_q;
    res.unit_id      = unit_q;
    res.stable_count = stable_q;
    res.absent_mask  = absent_q;
    res.event_count  = event_q;
  endtask

  task automatic write_reg(input logic idx, input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_LINK_MODE) link_mode_q = data[1:0];
    else local_tag_q = data[2:0];
    @(posedge clk_i);
  endtask

  // Stop offering, let every pending result drain, then load a new setting
  task automatic reconfigure(input logic [1:0] mode, input logic [2:0] tag);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    write_reg(REG_LINK_MODE, APB_DATA_W'(mode));
    write_reg(REG_LOCAL_TAG, APB_DATA_W'(tag));
  endtask

  task automatic offer_transfer(input item_t it, input logic typed, input result_t want);
    result_t predicted;
    int      gap;
    s_axis_tdata  <= pack_transfer(it);
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_transfer(it, predicted);
    pending_results.push_back(typed ? want : predicted);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = (steady_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  function automatic logic [15:0] pick_peer();
    case ($urandom_range(0, 9))
      0, 1, 2: return SEND_READY;
      3, 4:    return SEND_IDLE;
      5, 6:    return PEER_ABSENT;
      7:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] clean_peer();
    case ($urandom_range(0, 4))
      0, 1, 2: return SEND_READY;
      3:       return SEND_IDLE;
      default: return 16'($urandom) & 16'h7FFF;
    endcase
  endfunction

  task automatic next_transfer(output item_t it);
    int  k;
    logic [2:0] tag;
    it.link_id   = 2'($urandom);
    it.error_bit = 1'($urandom);
    it.rx_word0  = 16'($urandom);
    if (link_mode_q == MODE_STABLE || link_mode_q == MODE_STABLE_ALT) begin
      it.si_level = 1'($urandom);
      // mostly unchanged peers so the stability count can saturate
      if ($urandom_range(0, 99) < 96) begin
        it.rx_word1 = peer_hist[0];
        it.rx_word2 = peer_hist[1];
        it.rx_word3 = peer_hist[2];
      end else begin
        it.rx_word1 = pick_peer();
        it.rx_word2 = pick_peer();
        it.rx_word3 = pick_peer();
      end
    end else if (clean_left > 0) begin
      // well-formed run long enough to reach the ready state
      clean_left--;
      it.si_level = ($urandom_range(0, 99) < 97);
      it.rx_word0 = {($urandom_range(0, 9) == 0) ? 3'd0 : local_tag_q, expected_sequence()};
      it.rx_word1 = clean_peer();
      it.rx_word2 = clean_peer();
      it.rx_word3 = clean_peer();
    end else begin
      if ($urandom_range(0, 29) == 0) clean_left = $urandom_range(35, 80);
      it.si_level = ($urandom_range(0, 99) < 85);
      k = $urandom_range(0, 99);
      if (k < 5) begin
        it.rx_word0 = SEND_ABORT;
      end else if (k < 10) begin
        it.rx_word0 = {3'($urandom), 13'h1FF0 | 13'($urandom_range(0, 15))};
      end else if (k >= 20) begin
        k = $urandom_range(0, 9);
        tag = (k < 7) ? local_tag_q : (k < 9) ? 3'd0 : 3'($urandom);
        it.rx_word0 = {tag, expected_sequence()};
      end
      it.rx_word1 = pick_peer();
      it.rx_word2 = pick_peer();
      it.rx_word3 = pick_peer();
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      mismatch_count++;
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
    end else begin
      want = pending_results.pop_front();
      for (int k = 0; k < 10; k++) begin
        if (result_field(want, k) != result_field(got, k)) begin
          mismatch_count++;
          $display("%0t: %s expected %h actual %h", $time, field_names[k],
                   result_field(want, k), result_field(got, k));
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result(unpack_result(m_axis_tdata));
  end

  // Watchdog on cycles without any request moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: stall patterns in segments, plus one long hold-off on request
  initial begin
    int style;
    int seg_len;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      style = $urandom_range(0, 3);
      seg_len = $urandom_range(8, 64);
      repeat (seg_len) begin
        case (style)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          2:       m_axis_tready <= ($urandom_range(0, 1) != 0);
          default: m_axis_tready <= ($urandom_range(0, 4) == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin
    item_t   it;
    directed_row_t row;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    link_mode_q   = MODE_STABLE;
    local_tag_q   = '0;
    event_q       = '0;
    unit_q        = '0;
    error_q       = 1'b0;
    mismatch_q    = 1'b0;
    status_q      = STAT_OK;
    players_q     = '0;
    seq_q         = '0;
    good_q        = '0;
    absent_q      = '0;
    stable_q      = '0;
    for (int i = 0; i < 3; i++) peer_hist[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++) begin
      row = directed_rows[i];
      if (i == 0 || row.mode != link_mode_q || row.tag != local_tag_q)
        reconfigure(row.mode, row.tag);
      it.link_id   = row.id;
      it.error_bit = row.err;
      it.si_level  = row.si;
      it.rx_word0  = row.w0;
      it.rx_word1  = row.w1;
      it.rx_word2  = row.w2;
      it.rx_word3  = row.w3;
      offer_transfer(it, row.typed, row.want);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      reconfigure(phase_modes[p],
                  (p == 1) ? 3'd0 : (p == 2) ? 3'd7 : 3'($urandom_range(0, 7)));
      steady_sender = (p % 4 == 2);
      clean_left = 0;
      if (p == 4) hold_req = 1'b1;
      repeat (ITEMS_PER_PHASE) begin
        next_transfer(it);
        offer_transfer(it, 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
